/* rtl/core/dcmq_pkg.sv */
// Types and constants shared by the matrix-to-quaternion pipeline.
package dcmq_pkg;

  parameter int unsigned FRAC_BITS_DEF = 30;
  parameter int unsigned ELEM_W        = 32;
  parameter int unsigned NUM_W         = ELEM_W + 1;
  parameter int unsigned ARG_W         = ELEM_W + 3;
  parameter int unsigned RAD_W         = 64;
  parameter int unsigned ROOT_W        = RAD_W / 2;
  parameter int unsigned SQ_STEPS      = RAD_W / 2;
  parameter int unsigned DIV_W         = ROOT_W + 1;
  parameter int unsigned REM_W         = DIV_W + 2;
  parameter int unsigned LANES         = 3;

  typedef enum logic [1:0] {
    DIAG_X = 2'd0,
    DIAG_Y = 2'd1,
    DIAG_Z = 2'd2,
    DIAG_W = 2'd3
  } diag_e;

  typedef struct packed {
    logic signed [ELEM_W-1:0] c11;
    logic signed [ELEM_W-1:0] c12;
    logic signed [ELEM_W-1:0] c13;
    logic signed [ELEM_W-1:0] c21;
    logic signed [ELEM_W-1:0] c22;
    logic signed [ELEM_W-1:0] c23;
    logic signed [ELEM_W-1:0] c31;
    logic signed [ELEM_W-1:0] c32;
    logic signed [ELEM_W-1:0] c33;
  } in_word_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] qx;
    logic signed [ELEM_W-1:0] qy;
    logic signed [ELEM_W-1:0] qz;
    logic signed [ELEM_W-1:0] qw;
    logic                     degenerate;
  } out_word_t;

  // Per-word control and numerators that ride along the root pipeline.
  typedef struct packed {
    diag_e                   diag;
    logic                    degenerate;
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
  } side_t;

endpackage

/* rtl/core/dcm_to_quaternion_unit.sv */
// Pipelined direction cosine matrix to quaternion converter, Shepperd's method.
//
//  port       dir  handshake                payload
//  in_word_i  in   in_valid_i / in_ready_o  nine Q2.30 elements, row-major
//  out_word_o out  out_valid_o / out_ready_i qx qy qz qw (Q2.30), degenerate
//
// One word enters per cycle while the output is not stalled.
// Most of the pipe is the 32-step square root and the FRAC_BITS + 1 step
// dividers, each step one register stage.
// Reset clears only the valid bits; data registers are not reset.
// A stall on the output freezes the whole pipe; nothing is dropped or repeated.
module dcm_to_quaternion_unit
  import dcmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned DIV_STEPS = FRAC_BITS + 1;
  localparam int unsigned SAT_IDX   = 2 + SQ_STEPS;
  localparam int unsigned NSTG      = SAT_IDX + DIV_STEPS + 2;
  localparam int unsigned LAST      = NSTG - 1;

  localparam logic signed [ARG_W-1:0] OneArg = ARG_W'(1) << FRAC_BITS;
  localparam logic [ELEM_W-1:0]       OneU   = ELEM_W'(1) << FRAC_BITS;

  logic            adv;
  logic [NSTG-1:0] v_q;

  assign adv         = ~v_q[LAST] | out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = v_q[LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // ---------------- stage 1: trace and branch choice
  logic signed [ARG_W-1:0] tr;
  diag_e                   diag1_d;
  in_word_t                in1_q;
  diag_e                   diag1_q;

  always_comb begin
    tr = ARG_W'(in_word_i.c11) + ARG_W'(in_word_i.c22) + ARG_W'(in_word_i.c33);
    priority if (tr > 0) begin
      diag1_d = DIAG_W;
    end else if (in_word_i.c11 > in_word_i.c22 && in_word_i.c11 > in_word_i.c33) begin
      diag1_d = DIAG_X;
    end else if (in_word_i.c22 > in_word_i.c33) begin
      diag1_d = DIAG_Y;
    end else begin
      diag1_d = DIAG_Z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in1_q   <= in_word_i;
      diag1_q <= diag1_d;
    end
  end

  // ---------------- stage 2: root argument and numerators
  logic signed [ARG_W-1:0] arg;
  logic [ARG_W-1:0]        arg_pos;
  side_t                   side2_d;
  side_t                   side2_q;
  logic [RAD_W-1:0]        rad_q;

  always_comb begin
    side2_d.diag = diag1_q;
    unique case (diag1_q)
      DIAG_W: begin
        arg = OneArg + ARG_W'(in1_q.c11) + ARG_W'(in1_q.c22) + ARG_W'(in1_q.c33);
        side2_d.n0 = NUM_W'(in1_q.c32) - NUM_W'(in1_q.c23);
        side2_d.n1 = NUM_W'(in1_q.c13) - NUM_W'(in1_q.c31);
        side2_d.n2 = NUM_W'(in1_q.c21) - NUM_W'(in1_q.c12);
      end
      DIAG_X: begin
        arg = OneArg + ARG_W'(in1_q.c11) - ARG_W'(in1_q.c22) - ARG_W'(in1_q.c33);
        side2_d.n0 = NUM_W'(in1_q.c12) + NUM_W'(in1_q.c21);
        side2_d.n1 = NUM_W'(in1_q.c13) + NUM_W'(in1_q.c31);
        side2_d.n2 = NUM_W'(in1_q.c32) - NUM_W'(in1_q.c23);
      end
      DIAG_Y: begin
        arg = OneArg + ARG_W'(in1_q.c22) - ARG_W'(in1_q.c11) - ARG_W'(in1_q.c33);
        side2_d.n0 = NUM_W'(in1_q.c12) + NUM_W'(in1_q.c21);
        side2_d.n1 = NUM_W'(in1_q.c23) + NUM_W'(in1_q.c32);
        side2_d.n2 = NUM_W'(in1_q.c13) - NUM_W'(in1_q.c31);
      end
      DIAG_Z: begin
        arg = OneArg + ARG_W'(in1_q.c33) - ARG_W'(in1_q.c11) - ARG_W'(in1_q.c22);
        side2_d.n0 = NUM_W'(in1_q.c13) + NUM_W'(in1_q.c31);
        side2_d.n1 = NUM_W'(in1_q.c23) + NUM_W'(in1_q.c32);
        side2_d.n2 = NUM_W'(in1_q.c21) - NUM_W'(in1_q.c12);
      end
    endcase
    // clamp a negative argument; a zero root means no usable divisor
    side2_d.degenerate = (arg <= 0);
    arg_pos = side2_d.degenerate ? '0 : arg;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q <= side2_d;
      rad_q   <= {{(RAD_W-ARG_W){1'b0}}, arg_pos} << FRAC_BITS;
    end
  end

  // ---------------- stages 3..34: square root, one result bit per stage
  logic [RAD_W-1:0] sq_x_q [SQ_STEPS];
  logic [RAD_W-1:0] sq_r_q [SQ_STEPS];
  side_t            sq_s_q [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    localparam logic [RAD_W-1:0] Bit = RAD_W'(1) << (RAD_W - 2 - 2 * i);
    logic [RAD_W-1:0] x_in, r_in, t, x_nx, r_nx;
    side_t            s_in;

    if (i == 0) begin : g_first
      assign x_in = rad_q;
      assign r_in = '0;
      assign s_in = side2_q;
    end else begin : g_next
      assign x_in = sq_x_q[i-1];
      assign r_in = sq_r_q[i-1];
      assign s_in = sq_s_q[i-1];
    end

    always_comb begin
      t = r_in + Bit;
      if (x_in >= t) begin
        x_nx = x_in - t;
        r_nx = (r_in >> 1) + Bit;
      end else begin
        x_nx = x_in;
        r_nx = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_x_q[i] <= x_nx;
        sq_r_q[i] <= r_nx;
        sq_s_q[i] <= s_in;
      end
    end
  end

  // ---------------- saturation check and divider setup
  logic [ROOT_W-1:0]       h;
  logic [DIV_W-1:0]        dv;
  logic [ROOT_W-1:0]       hhalf;
  logic signed [NUM_W-1:0] num  [LANES];
  logic [NUM_W-1:0]        mag  [LANES];
  logic                    neg  [LANES];
  logic                    sat  [LANES];
  logic [RAD_W+1:0]        lim;

  logic [DIV_W-1:0]  dv3_q;
  logic [ROOT_W-1:0] hd3_q;
  side_t             s3_q;
  logic [NUM_W-1:0]  mag3_q [LANES];
  logic              neg3_q [LANES];
  logic              sat3_q [LANES];

  always_comb begin
    h      = sq_r_q[SQ_STEPS-1][ROOT_W-1:0];
    dv     = {h, 1'b0};
    hhalf  = h >> 1;
    num[0] = sq_s_q[SQ_STEPS-1].n0;
    num[1] = sq_s_q[SQ_STEPS-1].n1;
    num[2] = sq_s_q[SQ_STEPS-1].n2;
    lim    = ((RAD_W+2)'(dv) << FRAC_BITS) + (RAD_W+2)'(dv);
    for (int k = 0; k < LANES; k++) begin
      neg[k] = num[k][NUM_W-1];
      mag[k] = neg[k] ? (~num[k] + NUM_W'(1)) : num[k];
      // quotient would exceed one
      sat[k] = (((RAD_W+2)'(mag[k]) << FRAC_BITS) >= lim);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv3_q <= dv;
      hd3_q <= (hhalf > OneU) ? OneU : hhalf;
      s3_q  <= sq_s_q[SQ_STEPS-1];
      for (int k = 0; k < LANES; k++) begin
        mag3_q[k] <= mag[k];
        neg3_q[k] <= neg[k];
        sat3_q[k] <= sat[k];
      end
    end
  end

  // ---------------- divider stages, one quotient bit per stage per lane
  logic [REM_W-1:0]     dr_q   [DIV_STEPS][LANES];
  logic [DIV_STEPS-1:0] dq_q   [DIV_STEPS][LANES];
  logic                 dneg_q [DIV_STEPS][LANES];
  logic                 dsat_q [DIV_STEPS][LANES];
  logic [DIV_W-1:0]     dd_q   [DIV_STEPS];
  logic [ROOT_W-1:0]    dhd_q  [DIV_STEPS];
  side_t                ds_q   [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [REM_W-1:0]     r_in  [LANES];
    logic [DIV_STEPS-1:0] q_in  [LANES];
    logic                 b_in  [LANES];
    logic                 n_in  [LANES];
    logic                 s_in  [LANES];
    logic [REM_W-1:0]     r_sh  [LANES];
    logic [REM_W-1:0]     r_nx  [LANES];
    logic [DIV_STEPS-1:0] q_nx  [LANES];
    logic [DIV_W-1:0]     d_in;
    logic [ROOT_W-1:0]    hd_in;
    side_t                sd_in;

    if (j == 0) begin : g_first
      assign d_in  = dv3_q;
      assign hd_in = hd3_q;
      assign sd_in = s3_q;
      for (genvar k = 0; k < LANES; k++) begin : g_ln
        assign r_in[k] = REM_W'(mag3_q[k] >> 1);
        assign q_in[k] = '0;
        assign b_in[k] = mag3_q[k][0];
        assign n_in[k] = neg3_q[k];
        assign s_in[k] = sat3_q[k];
      end
    end else begin : g_next
      assign d_in  = dd_q[j-1];
      assign hd_in = dhd_q[j-1];
      assign sd_in = ds_q[j-1];
      for (genvar k = 0; k < LANES; k++) begin : g_ln
        assign r_in[k] = dr_q[j-1][k];
        assign q_in[k] = dq_q[j-1][k];
        assign b_in[k] = 1'b0;
        assign n_in[k] = dneg_q[j-1][k];
        assign s_in[k] = dsat_q[j-1][k];
      end
    end

    always_comb begin
      for (int k = 0; k < LANES; k++) begin
        r_sh[k] = {r_in[k][REM_W-2:0], b_in[k]};
        if (r_sh[k] >= REM_W'(d_in)) begin
          r_nx[k] = r_sh[k] - REM_W'(d_in);
          q_nx[k] = {q_in[k][DIV_STEPS-2:0], 1'b1};
        end else begin
          r_nx[k] = r_sh[k];
          q_nx[k] = {q_in[k][DIV_STEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dd_q[j]  <= d_in;
        dhd_q[j] <= hd_in;
        ds_q[j]  <= sd_in;
        for (int k = 0; k < LANES; k++) begin
          dr_q[j][k]   <= r_nx[k];
          dq_q[j][k]   <= q_nx[k];
          dneg_q[j][k] <= n_in[k];
          dsat_q[j][k] <= s_in[k];
        end
      end
    end
  end

  // ---------------- output stage: sign, saturate, place components
  logic [ELEM_W-1:0] lmag [LANES];
  logic [ELEM_W-1:0] lval [LANES];
  logic [ELEM_W-1:0] dg;
  side_t             sf;
  out_word_t         out_d;
  out_word_t         out_q;

  always_comb begin
    sf = ds_q[DIV_STEPS-1];
    dg = ELEM_W'(dhd_q[DIV_STEPS-1]);
    for (int k = 0; k < LANES; k++) begin
      lmag[k] = dsat_q[DIV_STEPS-1][k] ? OneU : ELEM_W'(dq_q[DIV_STEPS-1][k]);
      lval[k] = dneg_q[DIV_STEPS-1][k] ? (~lmag[k] + ELEM_W'(1)) : lmag[k];
    end
    unique case (sf.diag)
      DIAG_W: begin
        out_d.qx = lval[0]; out_d.qy = lval[1]; out_d.qz = lval[2]; out_d.qw = dg;
      end
      DIAG_X: begin
        out_d.qx = dg; out_d.qy = lval[0]; out_d.qz = lval[1]; out_d.qw = lval[2];
      end
      DIAG_Y: begin
        out_d.qx = lval[0]; out_d.qy = dg; out_d.qz = lval[1]; out_d.qw = lval[2];
      end
      DIAG_Z: begin
        out_d.qx = lval[0]; out_d.qy = lval[1]; out_d.qz = dg; out_d.qw = lval[2];
      end
    endcase
    out_d.degenerate = sf.degenerate;
    if (sf.degenerate) begin
      out_d.qx = '0;
      out_d.qy = '0;
      out_d.qz = '0;
      out_d.qw = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_word_o = out_q;

`ifndef SYNTHESIS
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.degenerate |->
      out_word_o.qx == 0 && out_word_o.qy == 0 &&
      out_word_o.qz == 0 && out_word_o.qw == 0)
    else $error("degenerate word carries nonzero components");

  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[SAT_IDX] && !s3_q.degenerate |-> dv3_q != '0)
    else $error("zero root on a non-degenerate word");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      $signed(out_word_o.qx) <= $signed(OneU) && $signed(out_word_o.qx) >= -$signed(OneU) &&
      $signed(out_word_o.qw) <= $signed(OneU) && $signed(out_word_o.qw) >= -$signed(OneU))
    else $error("component outside unit range");
`endif

endmodule
